>>> rtl/assert_macros.svh
// Assertion macros shared by the horizontal motion blur RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/hmb_pkg.sv
// Package of types and constants for the horizontal motion blur block.
`timescale 1ns / 1ps

package hmb_pkg;

   localparam int ROW_LENGTH = 512;
   localparam int MAX_BLUR   = 63;
   localparam int WIN_DEPTH  = 64;
   localparam int PTR_W      = $clog2(WIN_DEPTH);
   localparam int CNT_W      = PTR_W + 1;
   localparam int BLUR_W     = 6;
   localparam int COL_W      = $clog2(ROW_LENGTH);
   localparam int CHAN_W     = 8;
   localparam int NUM_CHAN   = 3;
   localparam int PIX_W      = CHAN_W * NUM_CHAN;
   localparam int SUM_W      = 14;
   localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_HEAD,
      ST_OWN,
      ST_ACC,
      ST_DLOAD,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic in_ready;
      logic accept;
      logic head_read;
      logic own_load;
      logic acc_add;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic emit_need;
      logic emit_last;
      logic nf_zero;
      logic acc_last;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

>>> rtl/hmb_div.sv
// Restoring divider for one colour channel, one quotient bit per cycle while step is high.
`timescale 1ns / 1ps

module hmb_div
   import hmb_pkg::*;
(
   input  logic              clock,
   input  logic              load,
   input  logic              step,
   input  logic [SUM_W-1:0]  dividend,
   input  logic [BLUR_W-1:0] divisor,
   output logic [SUM_W-1:0]  quotient
);

   logic [BLUR_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0]  dq_ff, dq_in;
   logic [BLUR_W:0]   trial;
   logic              fits;

   always_comb begin
      trial  = {rem_ff, dq_ff[SUM_W-1]};
      fits   = trial >= {1'b0, divisor};
      rem_in = fits ? BLUR_W'(trial - {1'b0, divisor}) : trial[BLUR_W-1:0];
      dq_in  = {dq_ff[SUM_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= '0;
         dq_ff  <= dividend;
      end else if (step) begin
         rem_ff <= rem_in;
         dq_ff  <= dq_in;
      end
   end

   assign quotient = dq_ff;

endmodule

>>> rtl/hmb_dp.sv
// Datapath: pixel window memory, row counters, follower sums, dividers and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hmb_dp
   import hmb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic              csr_wr_en,
   input  logic [BLUR_W-1:0] csr_wr_data,
   input  logic [PIX_W-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [PIX_W-1:0]  rsp_tdata,
   output logic              rsp_tuser,
   output logic              rsp_tlast
);

   logic [PIX_W-1:0]  win_mem [WIN_DEPTH];
   logic [PIX_W-1:0]  rdata_ff;
   logic [PTR_W-1:0]  rd_addr, wr_addr;

   logic [BLUR_W-1:0] blur_ff, blur_eff;
   logic [PTR_W-1:0]  head_ff;
   logic [CNT_W-1:0]  pending_ff, avail;
   logic [COL_W-1:0]  col_ff;
   logic              at_end_ff, at_end_now;
   logic [BLUR_W-1:0] nf_ff, nf_in, idx_ff;
   logic [PIX_W-1:0]  own_ff;
   logic [SUM_W-1:0]  sum_ff [NUM_CHAN];
   logic [SUM_W-1:0]  quot [NUM_CHAN];
   logic [DIV_CNT_W-1:0] div_cnt_ff;

   logic              out_valid_ff;
   logic [PIX_W-1:0]  out_pix_ff, out_pix_in;
   logic              out_row_end_ff, out_last_ff;
   logic              row_end_now;
   logic [CHAN_W:0]   mix [NUM_CHAN];

   assign blur_eff   = (blur_ff > BLUR_W'(MAX_BLUR)) ? BLUR_W'(MAX_BLUR) : blur_ff;
   assign at_end_now = col_ff >= COL_W'(ROW_LENGTH - 1);
   assign avail      = pending_ff - CNT_W'(1);
   assign nf_in      = at_end_ff ? ((avail < {1'b0, blur_eff}) ? avail[BLUR_W-1:0] : blur_eff)
                                 : blur_eff;
   assign wr_addr    = head_ff + pending_ff[PTR_W-1:0];
   assign rd_addr    = head_ff + ((cmd.own_load || cmd.acc_add) ?
                                  PTR_W'(idx_ff) + PTR_W'(1) : PTR_W'(0));
   assign row_end_now = at_end_ff && (pending_ff == CNT_W'(1));

   always_comb begin
      status.emit_need = at_end_ff ? (pending_ff != '0) : (pending_ff > {1'b0, blur_eff});
      status.emit_last = at_end_ff ? (pending_ff == CNT_W'(1))
                                   : (pending_ff == {1'b0, blur_eff} + CNT_W'(1));
      status.nf_zero   = (nf_ff == '0);
      status.acc_last  = (idx_ff == nf_ff);
      status.div_last  = (div_cnt_ff == DIV_CNT_W'(1));
      status.out_free  = !out_valid_ff || rsp_tready;
   end

   // Window memory: written when an item is taken, read one entry per cycle.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         win_mem[wr_addr] <= req_tdata;
      end
      rdata_ff <= win_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blur_ff    <= '0;
         head_ff    <= '0;
         pending_ff <= '0;
         col_ff     <= '0;
         at_end_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            blur_ff <= csr_wr_data;
         end
         if (cmd.accept) begin
            pending_ff <= pending_ff + CNT_W'(1);
            at_end_ff  <= at_end_now;
            col_ff     <= at_end_now ? '0 : col_ff + COL_W'(1);
         end else if (cmd.out_load) begin
            pending_ff <= pending_ff - CNT_W'(1);
            head_ff    <= head_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.head_read) begin
         nf_ff  <= nf_in;
         idx_ff <= '0;
      end else if (cmd.own_load || cmd.acc_add) begin
         idx_ff <= idx_ff + BLUR_W'(1);
      end
      if (cmd.own_load) begin
         own_ff <= rdata_ff;
      end
      if (cmd.div_load) begin
         div_cnt_ff <= DIV_CNT_W'(SUM_W);
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
      end
   end

   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
      always_ff @(posedge clock) begin
         if (cmd.own_load) begin
            sum_ff[c] <= '0;
         end else if (cmd.acc_add) begin
            sum_ff[c] <= sum_ff[c] + SUM_W'(rdata_ff[c*CHAN_W +: CHAN_W]);
         end
      end

      hmb_div u_div (
         .clock    (clock),
         .load     (cmd.div_load),
         .step     (cmd.div_step),
         .dividend (sum_ff[c]),
         .divisor  (nf_ff),
         .quotient (quot[c])
      );

      // The quotient is a mean of 8-bit values, so its low byte is all of it.
      assign mix[c] = {1'b0, own_ff[c*CHAN_W +: CHAN_W]} + {1'b0, quot[c][CHAN_W-1:0]};
      assign out_pix_in[c*CHAN_W +: CHAN_W] =
         (nf_ff == '0) ? own_ff[c*CHAN_W +: CHAN_W] : mix[c][CHAN_W:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_pix_ff     <= out_pix_in;
         out_row_end_ff <= row_end_now;
         out_last_ff    <= status.emit_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pix_ff;
   assign rsp_tuser  = out_row_end_ff;
   assign rsp_tlast  = out_last_ff;

   `ASSERT_NEXT(a_row_end_empties, clock, reset, cmd.out_load && row_end_now,
                pending_ff == '0, "window not empty after the last pixel of a row")
   `ASSERT_IMPLIES(a_row_end_col, clock, reset, cmd.out_load && row_end_now,
                   col_ff == '0, "row end emitted while the column counter is mid-row")
   `ASSERT_IMPLIES(a_quot_byte, clock, reset, cmd.out_load && (nf_ff != '0),
                   (quot[0][SUM_W-1:CHAN_W] == '0) && (quot[1][SUM_W-1:CHAN_W] == '0)
                   && (quot[2][SUM_W-1:CHAN_W] == '0), "mean of followers exceeds a byte")

endmodule

>>> rtl/hmb_ctrl.sv
// Controller state machine sequencing window reads, summing, division and emission.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hmb_ctrl
   import hmb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_CHECK;
         ST_CHECK: state_in = status.emit_need ? ST_HEAD : ST_IDLE;
         ST_HEAD:  state_in = ST_OWN;
         ST_OWN:   state_in = status.nf_zero ? ST_EMIT : ST_ACC;
         ST_ACC:   if (status.acc_last) state_in = ST_DLOAD;
         ST_DLOAD: state_in = ST_DIV;
         ST_DIV:   if (status.div_last) state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.emit_last ? ST_IDLE : ST_HEAD;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.in_ready = 1'b1;
            cmd.accept   = req_tvalid;
         end
         ST_HEAD:  cmd.head_read = 1'b1;
         ST_OWN:   cmd.own_load  = 1'b1;
         ST_ACC:   cmd.acc_add   = 1'b1;
         ST_DLOAD: cmd.div_load  = 1'b1;
         ST_DIV:   cmd.div_step  = 1'b1;
         ST_EMIT:  cmd.out_load  = status.out_free;
         default:  cmd = '0;
      endcase
   end

   `ASSERT_IMPLIES(a_div_needs_followers, clock, reset,
                   (state_ff == ST_ACC) || (state_ff == ST_DIV), !status.nf_zero,
                   "summing or dividing with no followers")
   `ASSERT_IMPLIES(a_accept_when_ready, clock, reset, cmd.accept,
                   cmd.in_ready && req_tvalid, "item taken while not ready")
   `ASSERT_IMPLIES(a_load_only_in_emit, clock, reset, cmd.out_load,
                   (state_ff == ST_EMIT) && status.out_free,
                   "output register loaded outside the emit state")

endmodule

>>> rtl/horizontal_motion_blur.sv
// Top level of the horizontal motion blur: controller and datapath.
`timescale 1ns / 1ps

// Horizontal motion blur over RGB pixels that arrive in row order, 512 pixels to a row.
// req_ carries one pixel per item; rsp_ returns blurred pixels in input order, with
// tuser marking the last pixel of a row and tlast the final result caused by an input.
// csr_wr_en writes the blur amount; write it only while the block is idle.
// An input item is taken in the idle state, then checked. Each result it releases passes
// the head, own, accumulate, divide-load, divide and emit states (nf = followers averaged,
// up to 63), skipping from own to emit when nf is 0. Accumulation reads the window memory
// one follower per cycle; a 14-step restoring divider forms each channel's follower mean.
// Results lag the input by blur_amount pixels; the last pixel of a row flushes them all.
// One item is processed at a time; req_tready is high only between items.
// A finished result sits in the output register; a new item may be taken while it waits,
// but the next result is held back until the receiver takes the one in place.
// Reset (synchronous, active high) empties the window, clears the row position and
// sets the blur amount to zero; window contents need no clearing.

module horizontal_motion_blur
   import hmb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [PIX_W-1:0]  req_tdata,   // red_in, green_in, blue_in
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [PIX_W-1:0]  rsp_tdata,   // red_out, green_out, blue_out
   output logic              rsp_tuser,   // row_end
   output logic              rsp_tlast,   // last_of_run
   input  logic              csr_wr_en,
   input  logic [BLUR_W-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   hmb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .cmd        (cmd)
   );

   hmb_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   assign req_tready = cmd.in_ready;

endmodule
